### design/rrbc_pkg.sv
// Shared types and constants for the ROM/RAM bank controller.
// No dependencies; rrbc_decode and the top level refer to it by scoped names.
`default_nettype none

package rrbc_pkg;

  // Memory window sizes and fixed codes
  localparam int unsigned RomWindowBits = 14;  // 0x4000 byte ROM window
  localparam int unsigned RamWindowBits = 13;  // 0x2000 byte RAM window
  localparam logic [7:0]  DisabledRead  = 8'hFF;
  localparam logic [3:0]  RamEnableKey  = 4'hA;
  localparam logic [7:0]  AdvancedMode  = 8'h01;

  // Reset values of the bank registers
  localparam logic [6:0]  RomBankReset  = 7'd1;
  localparam logic [1:0]  RamBankReset  = 2'd1;

  // Where a request lands
  typedef enum logic [1:0] {
    TGT_NONE    = 2'd0,  // register write or dropped RAM write
    TGT_MEM     = 2'd1,  // internal memory or ROM
    TGT_RAM     = 2'd2,  // external RAM
    TGT_RAM_OFF = 2'd3   // read of disabled external RAM
  } target_t;

  typedef enum logic {
    KIND_READ  = 1'b0,
    KIND_WRITE = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    target_t     target;
    logic        write_enable;
    logic [20:0] mem_address;
    logic [7:0]  data_out;
  } rsp_t;

  // Bank controller state handed between the top level and the decoder
  typedef struct packed {
    logic [6:0] rom_bank;
    logic [1:0] ram_bank;
    logic       ram_enable;
    logic       banking_mode;
  } bank_t;

endpackage

`default_nettype wire

### design/rrbc_stream_if.sv
// Valid/ready stream channel with a typed payload.
// Payload types come from rrbc_pkg at the point of instantiation.
`default_nettype none

interface rrbc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/rrbc_decode.sv
// Combinational translation of one bus request and next bank register values.
// Depends on rrbc_pkg for request, response and bank state types.
`default_nettype none

module rrbc_decode (
  input  wire rrbc_pkg::req_t  req,
  input  wire rrbc_pkg::bank_t bank,
  output rrbc_pkg::rsp_t  rsp,
  output rrbc_pkg::bank_t bank_next
);

  logic [3:0]  region;
  logic [20:0] rom_address;
  logic [20:0] ram_address;
  logic [6:0]  rom_sel;
  logic [6:0]  rom_bank_raw;
  logic [6:0]  rom_bank_fixed;

  assign region = req.bus_address[15:12];

  // Map the switchable ROM window into the selected bank
  assign rom_sel     = bank.rom_bank - 7'd1;
  assign rom_address = {rom_sel, {rrbc_pkg::RomWindowBits{1'b0}}}
                     + {5'd0, req.bus_address};

  // Offset into external RAM, banked only in RAM banking mode
  assign ram_address = bank.banking_mode
                     ? {6'd0, bank.ram_bank, req.bus_address[12:0]}
                     : {8'd0, req.bus_address[12:0]};

  // Candidate ROM bank for a bank select write
  always_comb begin
    rom_bank_raw = bank.rom_bank;
    if (region[3:1] == 3'b001) begin
      if (bank.banking_mode) begin
        rom_bank_raw = {2'b00, req.write_data[4:0]};
      end else begin
        rom_bank_raw = {bank.rom_bank[6:5], req.write_data[4:0]};
      end
    end else begin
      rom_bank_raw = {req.write_data[1:0], bank.rom_bank[4:0]};
    end
  end

  // Bump banks 0x00, 0x20, 0x40 and 0x60 to the next one
  assign rom_bank_fixed = (rom_bank_raw[4:0] == 5'd0) ? (rom_bank_raw | 7'd1) : rom_bank_raw;

  // Response and register updates
  always_comb begin
    rsp       = '0;
    bank_next = bank;
    if (req.kind == rrbc_pkg::KIND_READ) begin
      case (region)
        4'h4, 4'h5, 4'h6, 4'h7: begin
          rsp.target      = rrbc_pkg::TGT_MEM;
          rsp.mem_address = rom_address;
        end
        4'hA, 4'hB: begin
          if (bank.ram_enable) begin
            rsp.target      = rrbc_pkg::TGT_RAM;
            rsp.mem_address = ram_address;
          end else begin
            rsp.target   = rrbc_pkg::TGT_RAM_OFF;
            rsp.data_out = rrbc_pkg::DisabledRead;
          end
        end
        default: begin
          rsp.target      = rrbc_pkg::TGT_MEM;
          rsp.mem_address = {5'd0, req.bus_address};
        end
      endcase
    end else begin
      case (region)
        4'h0, 4'h1: begin
          bank_next.ram_enable = (req.write_data[3:0] == rrbc_pkg::RamEnableKey);
        end
        4'h2, 4'h3: begin
          bank_next.rom_bank = rom_bank_fixed;
        end
        4'h4, 4'h5: begin
          if (bank.banking_mode) begin
            bank_next.ram_bank = req.write_data[1:0];
          end else begin
            bank_next.rom_bank = rom_bank_fixed;
          end
        end
        4'h6, 4'h7: begin
          bank_next.banking_mode = (req.write_data == rrbc_pkg::AdvancedMode);
        end
        4'hA, 4'hB: begin
          // Drop the write while external RAM is disabled
          if (bank.ram_enable) begin
            rsp.target       = rrbc_pkg::TGT_RAM;
            rsp.write_enable = 1'b1;
            rsp.mem_address  = ram_address;
            rsp.data_out     = req.write_data;
          end
        end
        default: begin
          rsp.target       = rrbc_pkg::TGT_MEM;
          rsp.write_enable = 1'b1;
          rsp.mem_address  = {5'd0, req.bus_address};
          rsp.data_out     = req.write_data;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### design/rom_ram_bank_controller.sv
// Top level of the ROM/RAM bank controller: input register, bank registers,
// result register. Depends on rrbc_pkg, rrbc_stream_if and rrbc_decode.
//
//   channel  direction  payload                                       handshake
//   req      in         kind, bus_address, write_data                 valid/ready
//   rsp      out        target, write_enable, mem_address, data_out   valid/ready
//
// Each request yields one response: the request sits in the input register
// and passes through the decoder into the result register, which drives
// rsp.valid. Sustained rate is one request per cycle while rsp is not stalled;
// the bank registers update as a request leaves the input register, so the
// next request sees the new banks.
// Reset (rst, synchronous) empties both stages and loads the bank defaults.
// A stalled rsp holds both stages; req.ready drops only when both are full.
`default_nettype none

module rom_ram_bank_controller (
  input  wire logic      clk,
  input  wire logic      rst,
  rrbc_stream_if.sink    req,
  rrbc_stream_if.source  rsp
);

  logic            stage_valid;
  rrbc_pkg::req_t  stage_req;
  rrbc_pkg::bank_t bank;
  rrbc_pkg::bank_t bank_next;
  rrbc_pkg::rsp_t  result;
  logic            out_valid;
  rrbc_pkg::rsp_t  out_rsp;
  logic            out_free;
  logic            advance;

  // Stage moves forward when the result register is empty or being drained
  assign out_free  = !out_valid || rsp.ready;
  assign advance   = stage_valid && out_free;
  assign req.ready = !stage_valid || out_free;

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req.ready) begin
      stage_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      stage_req <= req.payload;
    end
  end

  rrbc_decode u_decode (
    .req       (stage_req),
    .bank      (bank),
    .rsp       (result),
    .bank_next (bank_next)
  );

  // Update bank registers as the request completes
  always_ff @(posedge clk) begin
    if (rst) begin
      bank.rom_bank     <= rrbc_pkg::RomBankReset;
      bank.ram_bank     <= rrbc_pkg::RamBankReset;
      bank.ram_enable   <= 1'b0;
      bank.banking_mode <= 1'b0;
    end else if (advance) begin
      bank <= bank_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= stage_valid;
    end
    if (advance) begin
      out_rsp <= result;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_rsp;

endmodule

`default_nettype wire

### dv/rom_ram_bank_controller_test.sv
// Testbench for the ROM/RAM bank controller: drives bus requests, predicts
// each translated access and checks every response in order.
// Depends on rrbc_pkg, rrbc_stream_if and rom_ram_bank_controller.
`timescale 1ns / 1ps

module rom_ram_bank_controller_test;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PrintLimit = 60;

  logic clk = 1'b0;
  logic rst;
  bit   idling_on;
  int unsigned cycle_count = 0;

  rrbc_stream_if #(.payload_t(rrbc_pkg::req_t)) req_ch ();
  rrbc_stream_if #(.payload_t(rrbc_pkg::rsp_t)) rsp_ch ();

  rom_ram_bank_controller u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Bank register mirror and queue of expected translated accesses
  class bank_scoreboard;
    logic [6:0]     rom_bank;
    logic [1:0]     ram_bank;
    logic           ram_on;
    logic           ram_mode;
    rrbc_pkg::rsp_t expected_q[$];
    int unsigned    fails;

    function new();
      rom_bank = rrbc_pkg::RomBankReset;
      ram_bank = rrbc_pkg::RamBankReset;
      ram_on   = 1'b0;
      ram_mode = 1'b0;
      fails    = 0;
    endfunction

    task report_mismatch(string msg);
      fails++;
      if (fails <= PrintLimit) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Skip banks whose low five bits are zero
    function void bump_dead_bank();
      if (rom_bank[4:0] == 5'd0) rom_bank = rom_bank + 7'd1;
    endfunction

    function logic [20:0] ram_offset(logic [15:0] addr);
      logic [20:0] off;
      off = {8'd0, addr[12:0]};
      if (ram_mode) off = off + {6'd0, ram_bank, 13'd0};
      return off;
    endfunction

    // Translate one request and apply its register side effects
    function rrbc_pkg::rsp_t translate_access(rrbc_pkg::req_t r);
      rrbc_pkg::rsp_t e;
      logic [3:0]     region;
      logic [7:0]     d;
      e = '0;
      e.target = rrbc_pkg::TGT_NONE;
      region = r.bus_address[15:12];
      d = r.write_data;
      if (r.kind == rrbc_pkg::KIND_READ) begin
        case (region)
          4'h4, 4'h5, 4'h6, 4'h7: begin
            e.target = rrbc_pkg::TGT_MEM;
            e.mem_address = {5'd0, r.bus_address} + {rom_bank - 7'd1, 14'd0};
          end
          4'hA, 4'hB: begin
            if (ram_on) begin
              e.target = rrbc_pkg::TGT_RAM;
              e.mem_address = ram_offset(r.bus_address);
            end else begin
              e.target = rrbc_pkg::TGT_RAM_OFF;
              e.data_out = rrbc_pkg::DisabledRead;
            end
          end
          default: begin
            e.target = rrbc_pkg::TGT_MEM;
            e.mem_address = {5'd0, r.bus_address};
          end
        endcase
      end else begin
        case (region)
          4'h0, 4'h1: ram_on = (d[3:0] == rrbc_pkg::RamEnableKey);
          4'h2, 4'h3: begin
            if (ram_mode) rom_bank = {2'b00, d[4:0]};
            else rom_bank = {rom_bank[6:5], d[4:0]};
            bump_dead_bank();
          end
          4'h4, 4'h5: begin
            if (ram_mode) begin
              ram_bank = d[1:0];
            end else begin
              rom_bank = {d[1:0], rom_bank[4:0]};
              bump_dead_bank();
            end
          end
          4'h6, 4'h7: ram_mode = (d == rrbc_pkg::AdvancedMode);
          4'hA, 4'hB: begin
            if (ram_on) begin
              e.target = rrbc_pkg::TGT_RAM;
              e.write_enable = 1'b1;
              e.mem_address = ram_offset(r.bus_address);
              e.data_out = d;
            end
          end
          default: begin
            e.target = rrbc_pkg::TGT_MEM;
            e.write_enable = 1'b1;
            e.mem_address = {5'd0, r.bus_address};
            e.data_out = d;
          end
        endcase
      end
      return e;
    endfunction

    function void note_request(rrbc_pkg::req_t r);
      expected_q.push_back(translate_access(r));
    endfunction

    task check_response(rrbc_pkg::rsp_t got);
      rrbc_pkg::rsp_t exp;
      if (expected_q.size() == 0) begin
        report_mismatch("response with no request outstanding");
      end else begin
        exp = expected_q.pop_front();
        if (got.target !== exp.target)
          report_mismatch($sformatf("target got %0d expected %0d", got.target, exp.target));
        if (got.write_enable !== exp.write_enable)
          report_mismatch($sformatf("write_enable got %0b expected %0b",
                                    got.write_enable, exp.write_enable));
        if (got.mem_address !== exp.mem_address)
          report_mismatch($sformatf("mem_address got %06h expected %06h",
                                    got.mem_address, exp.mem_address));
        if (got.data_out !== exp.data_out)
          report_mismatch($sformatf("data_out got %02h expected %02h",
                                    got.data_out, exp.data_out));
      end
    endtask
  endclass

  bank_scoreboard sb = new();

  // Clock and run limit
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Response side: check accepted responses, stall in random bursts
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.payload);
      if (idling_on && stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Present one request, hold it until accepted, then record it
  task automatic drive_request(rrbc_pkg::req_t r);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= r;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(r);
  endtask

  task automatic send(rrbc_pkg::kind_t k, logic [15:0] addr, logic [7:0] data);
    rrbc_pkg::req_t r;
    r.kind = k;
    r.bus_address = addr;
    r.write_data = data;
    drive_request(r);
  endtask

  // Random request biased toward bank registers, RAM window and window edges
  task automatic drive_random_access();
    rrbc_pkg::req_t r;
    int unsigned    pick;
    logic [3:0]     region;
    r.kind = rrbc_pkg::kind_t'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      r.bus_address = 16'($urandom);
    end else begin
      region = 4'($urandom_range(0, 15));
      if (pick >= 8) region = 4'hA + 4'($urandom_range(0, 1));
      r.bus_address[15:12] = region;
      if ($urandom_range(0, 3) == 0)
        r.bus_address[11:0] = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
      else
        r.bus_address[11:0] = 12'($urandom);
    end
    case ($urandom_range(0, 6))
      0: r.write_data = {4'($urandom), rrbc_pkg::RamEnableKey};
      1: r.write_data = rrbc_pkg::AdvancedMode;
      2: r.write_data = {3'($urandom), 5'd0};
      3: r.write_data = 8'($urandom_range(0, 3));
      default: r.write_data = 8'($urandom);
    endcase
    drive_request(r);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // Main sequence
  initial begin
    rst = 1'b1;
    idling_on = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset banks, disabled RAM, bank skips, both banking modes
    send(rrbc_pkg::KIND_READ,  16'h0000, 8'h00);
    send(rrbc_pkg::KIND_READ,  16'hFFFF, 8'hFF);
    send(rrbc_pkg::KIND_READ,  16'h4000, 8'h00);
    send(rrbc_pkg::KIND_READ,  16'hA000, 8'h00);
    send(rrbc_pkg::KIND_WRITE, 16'hA000, 8'h55);
    send(rrbc_pkg::KIND_WRITE, 16'hC000, 8'hFF);
    send(rrbc_pkg::KIND_WRITE, 16'h0000, 8'h0A);
    send(rrbc_pkg::KIND_READ,  16'hBFFF, 8'h00);
    send(rrbc_pkg::KIND_WRITE, 16'hA123, 8'h5A);
    send(rrbc_pkg::KIND_WRITE, 16'h2000, 8'h00);
    send(rrbc_pkg::KIND_WRITE, 16'h3FFF, 8'h1F);
    send(rrbc_pkg::KIND_WRITE, 16'h4000, 8'hFF);
    send(rrbc_pkg::KIND_READ,  16'h7FFF, 8'h00);
    send(rrbc_pkg::KIND_WRITE, 16'h2000, 8'h20);
    send(rrbc_pkg::KIND_READ,  16'h5000, 8'h00);
    send(rrbc_pkg::KIND_WRITE, 16'h6000, 8'h01);
    send(rrbc_pkg::KIND_WRITE, 16'h5FFF, 8'h03);
    send(rrbc_pkg::KIND_READ,  16'hB000, 8'h00);
    send(rrbc_pkg::KIND_WRITE, 16'h2000, 8'h40);
    send(rrbc_pkg::KIND_READ,  16'h4000, 8'h00);
    send(rrbc_pkg::KIND_WRITE, 16'h7FFF, 8'h81);
    send(rrbc_pkg::KIND_WRITE, 16'h4000, 8'h02);
    send(rrbc_pkg::KIND_WRITE, 16'h1FFF, 8'h1B);
    send(rrbc_pkg::KIND_READ,  16'hA000, 8'h00);
    send(rrbc_pkg::KIND_WRITE, 16'h8000, 8'h00);

    // Random with idling on both sides
    repeat (950) drive_random_access();

    // Hold off until every outstanding response has come back
    wait_drained();

    // Random, back to back, no stalls
    idling_on = 1'b0;
    repeat (300) drive_random_access();

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
design/rrbc_pkg.sv
design/rrbc_stream_if.sv
design/rrbc_decode.sv
design/rom_ram_bank_controller.sv
dv/rom_ram_bank_controller_test.sv
